FILE: rtl/trade_to_minute_ohlc_vwap_assert.svh
// Assertion macros used by the bar builder's top-level RTL file.
`ifndef TRADE_TO_MINUTE_OHLC_VWAP_ASSERT_SVH
`define TRADE_TO_MINUTE_OHLC_VWAP_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define TMOV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmov assertion failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define TMOV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmov assertion failed");

`endif

FILE: rtl/tmov_pkg.sv
// Types and constants shared by the bar builder's modules and interfaces.
package tmov_pkg;

  localparam int TIME_W     = 31;
  localparam int PRICE_W    = 32;
  localparam int VOL_W      = 32;
  localparam int NOTIONAL_W = 64;
  localparam int VOLSUM_W   = 48;
  localparam int COUNT_W    = 24;

  localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
  localparam int                MINUTE_SECS = 60;

  // Bars waiting between the accumulator and the divider.
  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic               start_batch;
    logic [TIME_W-1:0]  trade_time;
    logic [PRICE_W-1:0] trade_price;
    logic [VOL_W-1:0]   trade_volume;
  } trade_t;

  typedef struct packed {
    logic [TIME_W-1:0]   bar_time;
    logic [PRICE_W-1:0]  open_price;
    logic [PRICE_W-1:0]  high_price;
    logic [PRICE_W-1:0]  low_price;
    logic [PRICE_W-1:0]  close_price;
    logic [PRICE_W-1:0]  vwap_price;
    logic [VOLSUM_W-1:0] bar_volume;
    logic [COUNT_W-1:0]  trade_count;
  } bar_t;

  // A closed bar before its average price has been divided out.
  typedef struct packed {
    logic [TIME_W-1:0]     bar_time;
    logic [PRICE_W-1:0]    open_price;
    logic [PRICE_W-1:0]    high_price;
    logic [PRICE_W-1:0]    low_price;
    logic [PRICE_W-1:0]    close_price;
    logic [NOTIONAL_W-1:0] notional;
    logic [VOLSUM_W-1:0]   volume;
    logic [COUNT_W-1:0]    count;
  } acc_bar_t;

endpackage

FILE: rtl/tmov_ifs.sv
// Valid/ready channel interfaces for trades in and bars out.
interface tmov_trade_if import tmov_pkg::*; ();
  logic   valid;
  logic   ready;
  trade_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tmov_bar_if import tmov_pkg::*; ();
  logic valid;
  logic ready;
  bar_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tmov_front.sv
// Front end: takes trades, updates the open bar and hands closed bars on.
module tmov_front import tmov_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  tmov_trade_if.sink    in_trade,
  output logic          push_valid,
  input  logic          push_ready,
  output acc_bar_t      push_data
);

  localparam int                QUO_W    = 26;
  localparam int                QUO_LSB  = 35;
  localparam logic [31:0]       RECIP_15 = 32'h8888_8889;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [VOLSUM_W-1:0] VOLSUM_MAX = {VOLSUM_W{1'b1}};

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_ACC  = 3'b100
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic                start_r;
  logic [TIME_W-1:0]   time_r;
  logic [PRICE_W-1:0]  price_r;
  logic [VOL_W-1:0]    vol_r;
  logic [63:0]         prod_r;
  logic [QUO_W-1:0]    quo_r;

  logic [TIME_W-1:0]     boundary_r, boundary_nxt;
  logic [PRICE_W-1:0]    open_r, open_nxt;
  logic [PRICE_W-1:0]    high_r, high_nxt;
  logic [PRICE_W-1:0]    low_r, low_nxt;
  logic [PRICE_W-1:0]    close_r, close_nxt;
  logic [NOTIONAL_W-1:0] notional_r, notional_nxt;
  logic [VOLSUM_W-1:0]   volume_r, volume_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;

  logic [31:0]         round_sum;
  logic [61:0]         quo_prod;
  logic [31:0]         up_time;
  logic [TIME_W-1:0]   up_clamped;
  logic [TIME_W-1:0]   bound;
  logic [31:0]         bound_adv;

  logic [PRICE_W-1:0]    base_open, base_high, base_low;
  logic [NOTIONAL_W-1:0] base_notional;
  logic [VOLSUM_W-1:0]   base_volume;
  logic [COUNT_W-1:0]    base_count;
  logic [NOTIONAL_W:0]   notional_sum;
  logic [VOLSUM_W:0]     volume_sum;
  logic [PRICE_W-1:0]    upd_open, upd_high, upd_low;
  logic [NOTIONAL_W-1:0] upd_notional;
  logic [VOLSUM_W-1:0]   upd_volume;
  logic [COUNT_W-1:0]    upd_count;

  logic bar_close;
  logic acc_done;

  // Round-up to a minute: floor((t + 59) / 60) as (x / 4) / 15 by reciprocal.
  assign round_sum = {1'b0, time_r} + 32'(MINUTE_SECS - 1);
  assign quo_prod  = round_sum[31:2] * RECIP_15;

  assign up_time    = 32'(quo_r) * 32'(MINUTE_SECS);
  assign up_clamped = (up_time > {1'b0, TIME_MAX}) ? TIME_MAX : up_time[TIME_W-1:0];
  assign bound      = start_r ? up_clamped : boundary_r;
  assign bound_adv  = {1'b0, bound} + 32'(MINUTE_SECS);

  // A batch start accumulates into a freshly cleared bar.
  assign base_open     = start_r ? '0 : open_r;
  assign base_high     = start_r ? '0 : high_r;
  assign base_low      = start_r ? '1 : low_r;
  assign base_notional = start_r ? '0 : notional_r;
  assign base_volume   = start_r ? '0 : volume_r;
  assign base_count    = start_r ? '0 : count_r;

  assign notional_sum = {1'b0, base_notional} + {1'b0, prod_r};
  assign volume_sum   = {1'b0, base_volume} + (VOLSUM_W + 1)'(vol_r);

  assign upd_open     = (base_count == '0) ? price_r : base_open;
  assign upd_high     = (price_r > base_high) ? price_r : base_high;
  assign upd_low      = (price_r < base_low) ? price_r : base_low;
  assign upd_notional = notional_sum[NOTIONAL_W] ? '1 : notional_sum[NOTIONAL_W-1:0];
  assign upd_volume   = volume_sum[VOLSUM_W] ? VOLSUM_MAX : volume_sum[VOLSUM_W-1:0];
  assign upd_count    = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + 1'b1;

  assign bar_close = (time_r >= bound);
  assign acc_done  = (state_r == F_ACC) && (!bar_close || push_ready);

  assign push_valid = (state_r == F_ACC) && bar_close;
  always_comb begin
    push_data.bar_time    = bound;
    push_data.open_price  = upd_open;
    push_data.high_price  = upd_high;
    push_data.low_price   = upd_low;
    push_data.close_price = price_r;
    push_data.notional    = upd_notional;
    push_data.volume      = upd_volume;
    push_data.count       = upd_count;
  end

  assign in_trade.ready = (state_r == F_IDLE) || acc_done;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_trade.valid) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_ACC;
      F_ACC: begin
        if (acc_done) state_nxt = in_trade.valid ? F_MUL : F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    boundary_nxt = boundary_r;
    open_nxt     = open_r;
    high_nxt     = high_r;
    low_nxt      = low_r;
    close_nxt    = close_r;
    notional_nxt = notional_r;
    volume_nxt   = volume_r;
    count_nxt    = count_r;
    if (acc_done) begin
      if (bar_close) begin
        boundary_nxt = (bound_adv > {1'b0, TIME_MAX}) ? TIME_MAX : bound_adv[TIME_W-1:0];
        open_nxt     = '0;
        high_nxt     = '0;
        low_nxt      = '1;
        close_nxt    = '0;
        notional_nxt = '0;
        volume_nxt   = '0;
        count_nxt    = '0;
      end else begin
        boundary_nxt = bound;
        open_nxt     = upd_open;
        high_nxt     = upd_high;
        low_nxt      = upd_low;
        close_nxt    = price_r;
        notional_nxt = upd_notional;
        volume_nxt   = upd_volume;
        count_nxt    = upd_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      boundary_r <= '0;
      open_r     <= '0;
      high_r     <= '0;
      low_r      <= '1;
      close_r    <= '0;
      notional_r <= '0;
      volume_r   <= '0;
      count_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      boundary_r <= boundary_nxt;
      open_r     <= open_nxt;
      high_r     <= high_nxt;
      low_r      <= low_nxt;
      close_r    <= close_nxt;
      notional_r <= notional_nxt;
      volume_r   <= volume_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_trade.valid && in_trade.ready) begin
      start_r <= in_trade.data.start_batch;
      time_r  <= in_trade.data.trade_time;
      price_r <= in_trade.data.trade_price;
      vol_r   <= in_trade.data.trade_volume;
    end
    if (state_r == F_MUL) begin
      prod_r <= 64'(price_r) * 64'(vol_r);
      quo_r  <= quo_prod[QUO_LSB +: QUO_W];
    end
  end

endmodule

FILE: rtl/tmov_fifo.sv
// Short queue of closed bars between the accumulator and the divider.
module tmov_fifo import tmov_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  acc_bar_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output acc_bar_t pop_data
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  acc_bar_t           entry_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   fill_r;
  logic               do_push, do_pop;

  assign push_ready = (fill_r != CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: rtl/tmov_back.sv
// Back end: divides notional by volume one quotient bit a cycle and drives bars out.
module tmov_back import tmov_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  acc_bar_t    pop_data,
  tmov_bar_if.source  out_bar
);

  localparam int DIV_STEPS = NOTIONAL_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_OUT  = 3'b100
  } back_state_t;

  back_state_t            state_r, state_nxt;
  acc_bar_t               rec_r;
  logic [NOTIONAL_W-1:0]  dvd_r;
  logic [VOLSUM_W-1:0]    rem_r;
  logic [STEP_W-1:0]      step_r;
  logic                   out_valid_r;
  bar_t                   out_data_r;

  logic [VOLSUM_W:0]      trial;
  logic                   trial_ge;
  logic [VOLSUM_W:0]      trial_diff;
  logic [PRICE_W-1:0]     vwap;
  logic                   out_load;

  assign trial      = {rem_r, dvd_r[NOTIONAL_W-1]};
  assign trial_ge   = (trial >= {1'b0, rec_r.volume});
  assign trial_diff = trial - {1'b0, rec_r.volume};

  // The quotient only outgrows the price width once the volume sum has saturated.
  always_comb begin
    if (rec_r.volume == '0) begin
      vwap = '0;
    end else if (dvd_r[NOTIONAL_W-1:PRICE_W] != '0) begin
      vwap = '1;
    end else begin
      vwap = dvd_r[PRICE_W-1:0];
    end
  end

  assign pop_ready = (state_r == B_IDLE);
  assign out_load  = (state_r == B_OUT) && (!out_valid_r || out_bar.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (pop_valid) state_nxt = B_DIV;
      B_DIV:  if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = B_OUT;
      B_OUT:  if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bar.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          rec_r  <= pop_data;
          dvd_r  <= pop_data.notional;
          rem_r  <= '0;
          step_r <= '0;
        end
      end
      B_DIV: begin
        rem_r  <= trial_ge ? trial_diff[VOLSUM_W-1:0] : trial[VOLSUM_W-1:0];
        dvd_r  <= {dvd_r[NOTIONAL_W-2:0], trial_ge};
        step_r <= step_r + 1'b1;
      end
      B_OUT: begin
        if (out_load) begin
          out_data_r.bar_time    <= rec_r.bar_time;
          out_data_r.open_price  <= rec_r.open_price;
          out_data_r.high_price  <= rec_r.high_price;
          out_data_r.low_price   <= rec_r.low_price;
          out_data_r.close_price <= rec_r.close_price;
          out_data_r.vwap_price  <= vwap;
          out_data_r.bar_volume  <= rec_r.volume;
          out_data_r.trade_count <= rec_r.count;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_bar.valid = out_valid_r;
  assign out_bar.data  = out_data_r;

endmodule

FILE: rtl/trade_to_minute_ohlc_vwap.sv
// Top level of the one-minute OHLC and VWAP bar builder.
// Trades arrive on in_trade (valid/ready); a request is taken when both are high.
// Each trade updates open, high, low, close, notional, volume and count of the
// current bar; a trade at or past the minute boundary closes the bar, which
// is then sent on out_bar stamped with the boundary and its VWAP.
// A start_batch trade clears the bar and sets the boundary to its time
// rounded up to a whole minute before it is counted.
// Each trade passes the multiply stage and then the accumulate stage of the
// front end; the next trade can be taken while one is in the accumulate stage.
// A closed bar goes to out_bar through the 64-step restoring divider that
// forms its VWAP.
// Closed bars wait in a two-entry queue; the queue holds up the front end
// only when a bar closes while that queue is full.
// When the receiver stalls, the output register holds its bar and the
// divider waits after finishing the next one.
// rst_n (synchronous) clears the open bar, sets the boundary to zero and
// empties the queue and the output register; no clearing pass is needed.
module trade_to_minute_ohlc_vwap import tmov_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tmov_trade_if.sink in_trade,
  tmov_bar_if.source out_bar
);

`include "trade_to_minute_ohlc_vwap_assert.svh"

  logic     push_valid, push_ready;
  acc_bar_t push_data;
  logic     pop_valid, pop_ready;
  acc_bar_t pop_data;

  tmov_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_trade   (in_trade),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tmov_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tmov_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_bar   (out_bar)
  );

  // A closed bar that finds the queue full must still be offered next cycle.
  `TMOV_ASSERT_NEXT(a_push_held, push_valid && !push_ready, push_valid)
  `TMOV_ASSERT_NOW(a_vwap_zero_vol, out_bar.valid && (out_bar.data.bar_volume == '0), out_bar.data.vwap_price == '0)
  `TMOV_ASSERT_NOW(a_bar_range, out_bar.valid, (out_bar.data.trade_count != '0) && (out_bar.data.low_price <= out_bar.data.high_price))

endmodule

FILE: tb/trade_to_minute_ohlc_vwap_tb.sv
// Self-checking testbench for the one-minute OHLC and VWAP bar builder.
`timescale 1ns / 1ps

module trade_to_minute_ohlc_vwap_tb;
  import tmov_pkg::*;

  // A correct run stays well within CYCLE_LIMIT, even if every trade
  // closed a bar behind the divider with the slowest receiver and the long hold.
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int RANDOM_TRADES = 930;
  localparam int HOLD_CYCLES   = 4000;
  localparam int DRAIN_CYCLES  = 200;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tmov_trade_if trade_ch ();
  tmov_bar_if   bar_ch ();

  trade_to_minute_ohlc_vwap dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_trade (trade_ch),
    .out_bar  (bar_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  trade_t pending_trades[$];
  bar_t   expected_bars[$];

  // Running copy of the bar under construction.
  logic [TIME_W-1:0]     cur_boundary = '0;
  logic [PRICE_W-1:0]    cur_open     = '0;
  logic [PRICE_W-1:0]    cur_high     = '0;
  logic [PRICE_W-1:0]    cur_low      = '1;
  logic [PRICE_W-1:0]    cur_close    = '0;
  logic [NOTIONAL_W-1:0] cur_notional = '0;
  logic [VOLSUM_W-1:0]   cur_volume   = '0;
  logic [COUNT_W-1:0]    cur_count    = '0;

  int errors = 0;
  int unexpected_bars = 0;
  int trades_taken = 0;
  int bars_checked = 0;
  int empty_bars = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int mode_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  function automatic logic [TIME_W-1:0] clamp_secs(input longint secs);
    return (secs > longint'(TIME_MAX)) ? TIME_MAX : secs[TIME_W-1:0];
  endfunction

  function automatic void clear_bar();
    cur_open     = '0;
    cur_high     = '0;
    cur_low      = '1;
    cur_close    = '0;
    cur_notional = '0;
    cur_volume   = '0;
    cur_count    = '0;
  endfunction

  // Folds one accepted trade into the bar and queues the bar it closes, if any.
  function automatic void fold_trade(input trade_t tr);
    logic [NOTIONAL_W-1:0] prod;
    logic [NOTIONAL_W:0]   nsum;
    logic [VOLSUM_W:0]     vsum;
    logic [NOTIONAL_W-1:0] avg;
    bar_t                  b;
    if (tr.start_batch) begin
      clear_bar();
      cur_boundary = clamp_secs(((longint'(tr.trade_time) + MINUTE_SECS - 1) / MINUTE_SECS)
                                * MINUTE_SECS);
    end
    if (cur_count == '0) cur_open = tr.trade_price;
    if (tr.trade_price > cur_high) cur_high = tr.trade_price;
    if (tr.trade_price < cur_low) cur_low = tr.trade_price;
    cur_close = tr.trade_price;
    prod = NOTIONAL_W'(tr.trade_price) * NOTIONAL_W'(tr.trade_volume);
    nsum = {1'b0, cur_notional} + {1'b0, prod};
    cur_notional = nsum[NOTIONAL_W] ? '1 : nsum[NOTIONAL_W-1:0];
    vsum = {1'b0, cur_volume} + (VOLSUM_W + 1)'(tr.trade_volume);
    cur_volume = vsum[VOLSUM_W] ? '1 : vsum[VOLSUM_W-1:0];
    if (cur_count != '1) cur_count = cur_count + 1'b1;
    if (tr.trade_time >= cur_boundary) begin
      if (cur_volume == '0) begin
        b.vwap_price = '0;
      end else begin
        avg = cur_notional / NOTIONAL_W'(cur_volume);
        b.vwap_price = (avg > NOTIONAL_W'({PRICE_W{1'b1}})) ? '1 : avg[PRICE_W-1:0];
      end
      b.bar_time    = cur_boundary;
      b.open_price  = cur_open;
      b.high_price  = cur_high;
      b.low_price   = cur_low;
      b.close_price = cur_close;
      b.bar_volume  = cur_volume;
      b.trade_count = cur_count;
      expected_bars.insert(expected_bars.size(), b);
      clear_bar();
      cur_boundary = clamp_secs(longint'(cur_boundary) + MINUTE_SECS);
    end
  endfunction

  function automatic void add_trade(input logic s, input logic [TIME_W-1:0] t,
                                    input logic [PRICE_W-1:0] p, input logic [VOL_W-1:0] v);
    trade_t tr;
    tr.start_batch  = s;
    tr.trade_time   = t;
    tr.trade_price  = p;
    tr.trade_volume = v;
    pending_trades.insert(pending_trades.size(), tr);
  endfunction

  // Values near a typical level half the time, with the extremes and full-width noise mixed in.
  function automatic logic [31:0] rand_amount(input int unsigned centre,
                                              input int unsigned spread);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      default: return centre + $urandom_range(0, spread);
    endcase
  endfunction

  task automatic compare_field(input string fname, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (got_v !== want_v) begin
      if (errors < 10)
        $display("%0t: %s mismatch, expected %0d got %0d", $realtime, fname, want_v, got_v);
      errors++;
    end
  endtask

  // Driver: offers queued trades in bursts and holds a request until it is taken.
  always @(posedge clk) begin
    bit take;
    bit offer;
    take = trade_ch.valid && trade_ch.ready;
    if (!rst_n) begin
      trade_ch.valid <= 1'b0;
    end else begin
      if (take) begin
        fold_trade(trade_ch.data);
        void'(pending_trades.pop_front());
        trades_taken++;
      end
      if (!trade_ch.valid || take) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_trades.size() != 0) begin
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        trade_ch.valid <= offer;
        if (offer) trade_ch.data <= pending_trades[0];
      end
    end
  end

  // Once enough bars have come, the receiver holds off long enough to fill the block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && bars_checked >= 40) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    bit open_now;
    if (!rst_n) begin
      bar_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   open_now = 1'b1;
        RX_COIN:   open_now = 1'($urandom_range(0, 1));
        RX_SPARSE: open_now = (cycles % 5 == 0);
        default:   open_now = ($urandom_range(0, 9) != 0);
      endcase
      bar_ch.ready <= open_now && (hold_left == 0);
    end
  end

  // Monitor: every accepted bar is checked against the oldest expected bar.
  always @(posedge clk) begin
    bar_t want;
    if (rst_n && bar_ch.valid && bar_ch.ready) begin
      if (expected_bars.size() == 0) begin
        if (errors < 10)
          $display("%0t: bar at %0d arrived with none expected", $realtime,
                   bar_ch.data.bar_time);
        errors++;
        unexpected_bars++;
      end else begin
        want = expected_bars.pop_front();
        compare_field("bar_time", 64'(want.bar_time), 64'(bar_ch.data.bar_time));
        compare_field("open_price", 64'(want.open_price), 64'(bar_ch.data.open_price));
        compare_field("high_price", 64'(want.high_price), 64'(bar_ch.data.high_price));
        compare_field("low_price", 64'(want.low_price), 64'(bar_ch.data.low_price));
        compare_field("close_price", 64'(want.close_price), 64'(bar_ch.data.close_price));
        compare_field("vwap_price", 64'(want.vwap_price), 64'(bar_ch.data.vwap_price));
        compare_field("bar_volume", 64'(want.bar_volume), 64'(bar_ch.data.bar_volume));
        compare_field("trade_count", 64'(want.trade_count), 64'(bar_ch.data.trade_count));
        if (want.bar_volume == '0) empty_bars++;
      end
      bars_checked <= bars_checked + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bars outstanding", cycles,
               expected_bars.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    longint      now;
    int unsigned random_count;
    trade_ch.valid = 1'b0;
    trade_ch.data  = '0;
    bar_ch.ready   = 1'b0;
    now = 0;
    random_count = 0;

    // Without a batch start the boundary is still zero, so this closes a bar stamped 0.
    add_trade(1'b0, 12345, 1000, 5);
    // A start exactly on a minute closes its own bar; the first one has no volume.
    add_trade(1'b1, 0, 0, 0);
    add_trade(1'b1, 120, '1, '1);
    // Two maximal trades saturate the notional sum.
    add_trade(1'b1, 121, '1, '1);
    add_trade(1'b0, 125, '1, '1);
    add_trade(1'b0, 150, 0, '1);
    add_trade(1'b0, 180, 7, 1);
    // A jump in time closes one bar per trade while the boundary moves a minute at a time.
    add_trade(1'b0, 500, 42, 3);
    add_trade(1'b0, 500, 41, 2);
    // A whole bar without volume.
    add_trade(1'b1, 601, 5, 0);
    add_trade(1'b0, 650, 3, 0);
    add_trade(1'b0, 660, 9, 0);
    // A new batch in the middle of a bar throws the partial bar away.
    add_trade(1'b1, 700, 9, 11);
    add_trade(1'b1, 730, 8, 12);
    add_trade(1'b0, 779, '1, 1);
    add_trade(1'b0, 780, 0, 1);
    // Rounding up near the end of the time range saturates the boundary.
    add_trade(1'b1, TIME_W'(TIME_MAX - 6), 100, 1);
    add_trade(1'b0, TIME_MAX, 200, 2);
    add_trade(1'b0, TIME_MAX, 300, 3);
    add_trade(1'b1, TIME_MAX, '1, 0);

    while (random_count < RANDOM_TRADES) begin
      case ($urandom_range(0, 9))
        7: begin
          // Noise: unrelated times and random batch starts.
          repeat ($urandom_range(1, 6)) begin
            add_trade(1'($urandom_range(0, 1)), TIME_W'($urandom),
                      rand_amount(1_000_000, 5000), rand_amount(1, 999));
            random_count++;
          end
        end
        8, 9: begin
          // The stream goes on without a new batch start.
          repeat ($urandom_range(1, 12)) begin
            now = longint'(clamp_secs(now + $urandom_range(0, 25)));
            add_trade(1'b0, now[TIME_W-1:0], rand_amount(1_000_000, 5000),
                      rand_amount(1, 999));
            random_count++;
          end
        end
        default: begin
          case ($urandom_range(0, 3))
            0: now = longint'($urandom_range(0, 20000));
            1: now = longint'($urandom_range(0, TIME_MAX));
            2: now = longint'(TIME_MAX) - longint'($urandom_range(0, 400));
            default: now = longint'(clamp_secs(now + $urandom_range(1, 90)));
          endcase
          add_trade(1'b1, now[TIME_W-1:0], rand_amount(1_000_000, 5000),
                    rand_amount(1, 999));
          random_count++;
          repeat ($urandom_range(2, 40)) begin
            now = longint'(clamp_secs(now + (($urandom_range(0, 15) == 0) ?
                                    $urandom_range(60, 300) : $urandom_range(0, 20))));
            add_trade(1'b0, now[TIME_W-1:0], rand_amount(1_000_000, 5000),
                      rand_amount(1, 999));
            random_count++;
          end
        end
      endcase
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_trades.size() != 0 || trade_ch.valid || expected_bars.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d trades and %0d closed bars, %0d of them with no volume.",
             trades_taken, bars_checked, empty_bars);
    $display("Receiver hold-off done: %0d; field mismatches and stray bars: %0d, %0d.",
             hold_done, errors - unexpected_bars, unexpected_bars);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
